// ===== rtl/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the command frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned POS_W       = 4;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_HDR   = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHECK = 2'd2;

   localparam logic [7:0] GEAR_ONE   = 8'd1;
   localparam logic [7:0] GEAR_TWO   = 8'd2;
   localparam logic [7:0] GEAR_THREE = 8'd3;

   localparam logic [2:0] REG_SYNC_WORD     = 3'd0;
   localparam logic [2:0] REG_COMMAND_LIMIT = 3'd1;
   localparam logic [2:0] REG_GEAR_ONE      = 3'd2;
   localparam logic [2:0] REG_GEAR_TWO      = 3'd3;
   localparam logic [2:0] REG_GEAR_THREE    = 3'd4;

   localparam logic [15:0] SYNC_WORD_RST     = 16'hABCD;
   localparam logic [14:0] COMMAND_LIMIT_RST = 15'd1000;
   localparam logic [7:0]  GEAR_ONE_RST      = 8'd60;
   localparam logic [7:0]  GEAR_TWO_RST      = 8'd90;
   localparam logic [7:0]  GEAR_THREE_RST    = 8'd120;

   typedef struct packed {
      logic [15:0] header_word;
      logic [15:0] steer_word;
      logic [15:0] speed_word;
      logic [7:0]  gear_byte;
      logic [7:0]  spare_byte;
      logic [15:0] check_word;
   } frame_type;

   typedef struct packed {
      logic [15:0] sync_word;
      logic [14:0] command_limit;
      logic [7:0]  gear_one_angle;
      logic [7:0]  gear_two_angle;
      logic [7:0]  gear_three_angle;
   } config_type;

   typedef struct packed {
      logic [7:0]         servo_angle;
      logic               angle_valid;
      logic [7:0]         gear_code;
      logic signed [15:0] speed_value;
      logic signed [15:0] steer_value;
      logic [1:0]         frame_status;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/command_frame_checker.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker
// Gathers 10-byte command frames from a byte stream and reports status,
// clamped steer and speed, gear and servo angle once per frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle without pause while the result side
// keeps up. Bytes pass through a frame register and then a result register,
// each with its own valid bit, so a stalled result holds back new bytes only
// once both are full. Frames are not resynchronized: after every tenth byte
// the next byte starts a new frame, whatever the status.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] frame_status, [17:2] steer_value, [33:18] speed_value,
   // [41:34] gear_code, [42] angle_valid, [50:43] servo_angle, [55:51] zero
   output logic [55:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfc_pkg::config_type cfg_ff, cfg_in;
   cfc_pkg::frame_type  frame;
   cfc_pkg::result_type result;
   logic                frame_valid;
   logic                frame_ready;
   logic                cfg_write;
   logic [2:0]          reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            cfc_pkg::REG_SYNC_WORD:     cfg_in.sync_word        = csr_pwdata[15:0];
            cfc_pkg::REG_COMMAND_LIMIT: cfg_in.command_limit    = csr_pwdata[14:0];
            cfc_pkg::REG_GEAR_ONE:      cfg_in.gear_one_angle   = csr_pwdata[7:0];
            cfc_pkg::REG_GEAR_TWO:      cfg_in.gear_two_angle   = csr_pwdata[7:0];
            cfc_pkg::REG_GEAR_THREE:    cfg_in.gear_three_angle = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         cfc_pkg::REG_SYNC_WORD:     csr_prdata = {16'd0, cfg_ff.sync_word};
         cfc_pkg::REG_COMMAND_LIMIT: csr_prdata = {17'd0, cfg_ff.command_limit};
         cfc_pkg::REG_GEAR_ONE:      csr_prdata = {24'd0, cfg_ff.gear_one_angle};
         cfc_pkg::REG_GEAR_TWO:      csr_prdata = {24'd0, cfg_ff.gear_two_angle};
         cfc_pkg::REG_GEAR_THREE:    csr_prdata = {24'd0, cfg_ff.gear_three_angle};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word        <= cfc_pkg::SYNC_WORD_RST;
         cfg_ff.command_limit    <= cfc_pkg::COMMAND_LIMIT_RST;
         cfg_ff.gear_one_angle   <= cfc_pkg::GEAR_ONE_RST;
         cfg_ff.gear_two_angle   <= cfc_pkg::GEAR_TWO_RST;
         cfg_ff.gear_three_angle <= cfc_pkg::GEAR_THREE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfc_collector u_collector (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .byte_ready  (req_tready),
      .byte_data   (req_tdata),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   cfc_check u_check (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .frame_valid  (frame_valid),
      .frame_ready  (frame_ready),
      .frame        (frame),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {5'd0, result};

endmodule

`default_nettype wire

// ===== rtl/cfc_collector.sv =====
// ----------------------------------------------------------------------------
// cfc_collector
// Gathers bytes into a 10-byte frame and hands the whole frame on through
// a registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_collector (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 byte_valid,
   output logic                byte_ready,
   input  wire  [7:0]          byte_data,
   output logic                frame_valid,
   input  wire                 frame_ready,
   output cfc_pkg::frame_type  frame
);

   logic [cfc_pkg::POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [15:0]               header_ff, header_in;
   logic [15:0]               steer_ff, steer_in;
   logic [15:0]               speed_ff, speed_in;
   logic [7:0]                gear_ff, gear_in;
   logic [7:0]                spare_ff, spare_in;
   logic [7:0]                check_low_ff, check_low_in;
   logic                      frame_valid_ff, frame_valid_in;
   cfc_pkg::frame_type        frame_ff, frame_in;
   logic                      take;
   logic                      last;

   assign byte_ready = !frame_valid_ff || frame_ready;
   assign take       = byte_valid && byte_ready;
   assign pos_cur    = (pos_ff > cfc_pkg::POS_LAST) ? '0 : pos_ff;
   assign last       = (pos_cur == cfc_pkg::POS_LAST);

   always_comb begin
      pos_in       = pos_ff;
      header_in    = header_ff;
      steer_in     = steer_ff;
      speed_in     = speed_ff;
      gear_in      = gear_ff;
      spare_in     = spare_ff;
      check_low_in = check_low_ff;
      if (take) begin
         pos_in = last ? '0 : pos_cur + 1'b1;
         case (pos_cur)
            4'd0: header_in[7:0]  = byte_data;
            4'd1: header_in[15:8] = byte_data;
            4'd2: steer_in[7:0]   = byte_data;
            4'd3: steer_in[15:8]  = byte_data;
            4'd4: speed_in[7:0]   = byte_data;
            4'd5: speed_in[15:8]  = byte_data;
            4'd6: gear_in         = byte_data;
            4'd7: spare_in        = byte_data;
            4'd8: check_low_in    = byte_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      frame_valid_in = frame_valid_ff && !frame_ready;
      frame_in       = frame_ff;
      if (take && last) begin
         frame_valid_in       = 1'b1;
         frame_in.header_word = header_ff;
         frame_in.steer_word  = steer_ff;
         frame_in.speed_word  = speed_ff;
         frame_in.gear_byte   = gear_ff;
         frame_in.spare_byte  = spare_ff;
         frame_in.check_word  = {byte_data, check_low_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         header_ff      <= '0;
         steer_ff       <= '0;
         speed_ff       <= '0;
         gear_ff        <= '0;
         spare_ff       <= '0;
         check_low_ff   <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         header_ff      <= header_in;
         steer_ff       <= steer_in;
         speed_ff       <= speed_in;
         gear_ff        <= gear_in;
         spare_ff       <= spare_in;
         check_low_ff   <= check_low_in;
         frame_valid_ff <= frame_valid_in;
      end
      frame_ff <= frame_in;
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

endmodule

`default_nettype wire

// ===== rtl/cfc_check.sv =====
// ----------------------------------------------------------------------------
// cfc_check
// Checks header and checksum of a frame, clamps the commands, maps the gear
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_check (
   input  wire                  clock,
   input  wire                  reset,
   input  cfc_pkg::config_type  cfg,
   input  wire                  frame_valid,
   output logic                 frame_ready,
   input  cfc_pkg::frame_type   frame,
   output logic                 result_valid,
   input  wire                  result_ready,
   output cfc_pkg::result_type  result
);

   logic                 result_valid_ff, result_valid_in;
   cfc_pkg::result_type  result_ff, result_in;
   logic [15:0]          expect_word;
   logic signed [16:0]   lim_pos;
   logic signed [16:0]   lim_neg;

   function automatic logic signed [15:0] clamp_cmd(input logic [15:0] w,
                                                    input logic signed [16:0] hi,
                                                    input logic signed [16:0] lo);
      logic signed [16:0] v;
      logic signed [16:0] r;
      begin
         v = {w[15], w};
         r = v;
         if (v > hi) r = hi;
         if (v < lo) r = lo;
         clamp_cmd = r[15:0];
      end
   endfunction

   assign frame_ready = !result_valid_ff || result_ready;
   assign lim_pos     = {2'b00, cfg.command_limit};
   assign lim_neg     = -lim_pos;
   assign expect_word = frame.header_word ^ frame.steer_word ^ frame.speed_word ^
                        {frame.spare_byte, frame.gear_byte};

   always_comb begin
      result_valid_in = result_valid_ff && !result_ready;
      result_in       = result_ff;
      if (frame_valid && frame_ready) begin
         result_valid_in = 1'b1;
         result_in       = '0;
         result_in.gear_code = frame.gear_byte;
         if (frame.header_word != cfg.sync_word) begin
            result_in.frame_status = cfc_pkg::STATUS_BAD_HDR;
         end else if (frame.check_word != expect_word) begin
            result_in.frame_status = cfc_pkg::STATUS_BAD_CHECK;
         end else begin
            result_in.frame_status = cfc_pkg::STATUS_OK;
            result_in.steer_value  = clamp_cmd(frame.steer_word, lim_pos, lim_neg);
            result_in.speed_value  = clamp_cmd(frame.speed_word, lim_pos, lim_neg);
            case (frame.gear_byte)
               cfc_pkg::GEAR_ONE: begin
                  result_in.angle_valid = 1'b1;
                  result_in.servo_angle = cfg.gear_one_angle;
               end
               cfc_pkg::GEAR_TWO: begin
                  result_in.angle_valid = 1'b1;
                  result_in.servo_angle = cfg.gear_two_angle;
               end
               cfc_pkg::GEAR_THREE: begin
                  result_in.angle_valid = 1'b1;
                  result_in.servo_angle = cfg.gear_three_angle;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else begin
         result_valid_ff <= result_valid_in;
      end
      result_ff <= result_in;
   end

   assign result_valid = result_valid_ff;
   assign result       = result_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_checker testbench
// Feeds 10-byte command frames, well formed, broken and random, into the
// byte stream and predicts every frame result: status, clamped commands, raw
// gear and servo angle. Register settings change between phases, and both
// stream sides idle and stall at varying rates, including one long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------

module testbench;

   localparam int          FRAMES_PER_PHASE  = 15;
   localparam int          PHASE_COUNT       = 8;
   localparam int          HOLD_CYCLES       = 400;
   localparam int          SETTLE_CYCLES     = 6;
   localparam int unsigned WATCHDOG_LIMIT    = 3000;
   localparam int          REG_UNMAPPED_LOW  = 5;
   localparam int          REG_UNMAPPED_HIGH = 7;

   class frame_tracker;
      logic [15:0] header_match;
      logic [14:0] limit;
      logic [7:0]  angle_one, angle_two, angle_three;
      logic [3:0]  position;
      logic [15:0] header_word, steer_word, speed_word;
      logic [7:0]  gear_byte, spare_byte, check_low;
      cfc_pkg::result_type expected_results[$];
      int unsigned failures;

      function new();
         header_match = cfc_pkg::SYNC_WORD_RST;
         limit        = cfc_pkg::COMMAND_LIMIT_RST;
         angle_one    = cfc_pkg::GEAR_ONE_RST;
         angle_two    = cfc_pkg::GEAR_TWO_RST;
         angle_three  = cfc_pkg::GEAR_THREE_RST;
         position     = '0;
         header_word  = '0;
         steer_word   = '0;
         speed_word   = '0;
         gear_byte    = '0;
         spare_byte   = '0;
         check_low    = '0;
         failures     = 0;
      endfunction

      function void set_reg(logic [2:0] index, logic [31:0] value);
         case (index)
            cfc_pkg::REG_SYNC_WORD:     header_match = value[15:0];
            cfc_pkg::REG_COMMAND_LIMIT: limit        = value[14:0];
            cfc_pkg::REG_GEAR_ONE:      angle_one    = value[7:0];
            cfc_pkg::REG_GEAR_TWO:      angle_two    = value[7:0];
            cfc_pkg::REG_GEAR_THREE:    angle_three  = value[7:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] index);
         case (index)
            cfc_pkg::REG_SYNC_WORD:     return 32'(header_match);
            cfc_pkg::REG_COMMAND_LIMIT: return 32'(limit);
            cfc_pkg::REG_GEAR_ONE:      return 32'(angle_one);
            cfc_pkg::REG_GEAR_TWO:      return 32'(angle_two);
            cfc_pkg::REG_GEAR_THREE:    return 32'(angle_three);
            default:                    return '0;
         endcase
      endfunction

      function logic signed [15:0] clamp_command(logic [15:0] word);
         int value, bound;
         value = int'(signed'(word));
         bound = int'(limit);
         if (value > bound) value = bound;
         if (value < -bound) value = -bound;
         return 16'(value);
      endfunction

      function void take_byte(logic [7:0] rx);
         logic [15:0] check_word, check_sum;
         cfc_pkg::result_type want;
         if (position >= cfc_pkg::FRAME_BYTES) position = '0;
         case (position)
            4'd0: header_word[7:0]  = rx;
            4'd1: header_word[15:8] = rx;
            4'd2: steer_word[7:0]   = rx;
            4'd3: steer_word[15:8]  = rx;
            4'd4: speed_word[7:0]   = rx;
            4'd5: speed_word[15:8]  = rx;
            4'd6: gear_byte         = rx;
            4'd7: spare_byte        = rx;
            4'd8: check_low         = rx;
            default: ;
         endcase
         if (position != cfc_pkg::POS_LAST) begin
            position++;
            return;
         end
         position   = '0;
         check_word = {rx, check_low};
         check_sum  = header_word ^ steer_word ^ speed_word ^ {spare_byte, gear_byte};
         want           = '0;
         want.gear_code = gear_byte;
         if (header_word != header_match) begin
            want.frame_status = cfc_pkg::STATUS_BAD_HDR;
         end else if (check_word != check_sum) begin
            want.frame_status = cfc_pkg::STATUS_BAD_CHECK;
         end else begin
            want.frame_status = cfc_pkg::STATUS_OK;
            want.steer_value  = clamp_command(steer_word);
            want.speed_value  = clamp_command(speed_word);
            case (gear_byte)
               cfc_pkg::GEAR_ONE: begin
                  want.angle_valid = 1'b1;
                  want.servo_angle = angle_one;
               end
               cfc_pkg::GEAR_TWO: begin
                  want.angle_valid = 1'b1;
                  want.servo_angle = angle_two;
               end
               cfc_pkg::GEAR_THREE: begin
                  want.angle_valid = 1'b1;
                  want.servo_angle = angle_three;
               end
               default: ;
            endcase
         end
         expected_results.push_back(want);
      endfunction

      function void check_field(string field, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void compare_result(logic [55:0] data);
         cfc_pkg::result_type want, got;
         if (expected_results.size() == 0) begin
            $error("frame result with no frame pending: %h", data);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         got  = data[50:0];
         check_field("frame_status", int'(want.frame_status), int'(got.frame_status));
         check_field("steer_value", int'(want.steer_value), int'(got.steer_value));
         check_field("speed_value", int'(want.speed_value), int'(got.speed_value));
         check_field("gear_code", int'(want.gear_code), int'(got.gear_code));
         check_field("angle_valid", int'(want.angle_valid), int'(got.angle_valid));
         check_field("servo_angle", int'(want.servo_angle), int'(got.servo_angle));
         check_field("padding", 0, int'(data[55:51]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [1:0] frame_status, [17:2] steer_value, [33:18] speed_value,
   // [41:34] gear_code, [42] angle_valid, [50:43] servo_angle, [55:51] zero
   logic [55:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_tracker tracker = new();
   int           req_idle_pct  = 0;
   int           rsp_stall_pct = 0;
   int           hold_remaining = 0;
   int unsigned  quiet_cycles = 0;

   string reg_label [5] = '{"sync_word", "command_limit", "gear_one_angle",
                            "gear_two_angle", "gear_three_angle"};

   command_frame_checker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic bit chance(int pct);
      return int'($urandom_range(0, 99)) < pct;
   endfunction

   // result side: random stalls, or a long hold-off when requested
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_remaining > 0) begin
            hold_remaining--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !chance(rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.compare_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while (chance(req_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_byte(value);
   endtask

   task automatic send_frame(input cfc_pkg::frame_type frame);
      send_byte(frame.header_word[7:0]);
      send_byte(frame.header_word[15:8]);
      send_byte(frame.steer_word[7:0]);
      send_byte(frame.steer_word[15:8]);
      send_byte(frame.speed_word[7:0]);
      send_byte(frame.speed_word[15:8]);
      send_byte(frame.gear_byte);
      send_byte(frame.spare_byte);
      send_byte(frame.check_word[7:0]);
      send_byte(frame.check_word[15:8]);
   endtask

   function automatic cfc_pkg::frame_type sealed_frame(logic [15:0] header,
                                                       logic [15:0] steer,
                                                       logic [15:0] speed,
                                                       logic [7:0] gear,
                                                       logic [7:0] spare);
      cfc_pkg::frame_type frame;
      frame.header_word = header;
      frame.steer_word  = steer;
      frame.speed_word  = speed;
      frame.gear_byte   = gear;
      frame.spare_byte  = spare;
      frame.check_word  = header ^ steer ^ speed ^ {spare, gear};
      return frame;
   endfunction

   function automatic logic [15:0] pick_command();
      int bound;
      bound = int'(tracker.limit);
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'(bound);
         3:       return 16'(-bound);
         4:       return 16'(bound + 1);
         5:       return 16'(-bound - 1);
         6:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_gear();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return cfc_pkg::GEAR_ONE;
         2:       return cfc_pkg::GEAR_TWO;
         3:       return cfc_pkg::GEAR_THREE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_frame();
      cfc_pkg::frame_type frame;
      frame = sealed_frame(tracker.header_match, pick_command(), pick_command(),
                           pick_gear(), 8'($urandom));
      case ($urandom_range(0, 9))
         0:       frame.header_word ^= 16'($urandom_range(1, 65535));
         1:       frame.check_word  ^= 16'($urandom_range(1, 65535));
         2:       frame = cfc_pkg::frame_type'(80'({$urandom, $urandom, $urandom}));
         default: ;
      endcase
      send_frame(frame);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_reg(index, value);
      @(posedge clock);
   endtask

   task automatic verify_reg(input logic [2:0] index);
      logic [31:0] value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (value !== tracker.reg_value(index)) begin
         $error("%s: expected %h, actual %h", reg_label[index],
                tracker.reg_value(index), value);
         tracker.failures++;
      end
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input int phase);
      case (phase)
         0: ;
         1: begin
            write_reg(cfc_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF);
            write_reg(cfc_pkg::REG_COMMAND_LIMIT, 32'h0000_8000);
            write_reg(cfc_pkg::REG_GEAR_ONE, 32'd0);
            write_reg(cfc_pkg::REG_GEAR_TWO, 32'd180);
            write_reg(cfc_pkg::REG_GEAR_THREE, 32'hFFFF_FFFF);
            write_reg(3'($urandom_range(REG_UNMAPPED_LOW, REG_UNMAPPED_HIGH)), $urandom);
         end
         2: begin
            write_reg(cfc_pkg::REG_SYNC_WORD, 32'hFFFF_0000);
            write_reg(cfc_pkg::REG_COMMAND_LIMIT, 32'hFFFF_FFFF);
            write_reg(cfc_pkg::REG_GEAR_ONE, 32'd180);
            write_reg(cfc_pkg::REG_GEAR_TWO, 32'd0);
            write_reg(cfc_pkg::REG_GEAR_THREE, 32'd1);
         end
         default: begin
            write_reg(cfc_pkg::REG_SYNC_WORD, $urandom);
            write_reg(cfc_pkg::REG_COMMAND_LIMIT, $urandom);
            write_reg(cfc_pkg::REG_GEAR_ONE, $urandom_range(0, 180));
            write_reg(cfc_pkg::REG_GEAR_TWO, $urandom_range(0, 180));
            write_reg(cfc_pkg::REG_GEAR_THREE, $urandom_range(0, 180));
            write_reg(3'($urandom_range(REG_UNMAPPED_LOW, REG_UNMAPPED_HIGH)), $urandom);
         end
      endcase
      for (int idx = int'(cfc_pkg::REG_SYNC_WORD); idx <= int'(cfc_pkg::REG_GEAR_THREE);
           idx++) verify_reg(3'(idx));
   endtask

   initial begin
      cfc_pkg::frame_type frame;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         apply_settings(phase);
         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 72;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 72;
            end
            default: begin
               req_idle_pct  = 28;
               rsp_stall_pct = 28;
            end
         endcase
         if (phase == 0) begin
            // clamped extremes with gear one, bad header, bad checksum
            send_frame(sealed_frame(cfc_pkg::SYNC_WORD_RST, 16'h8000, 16'h7FFF,
                                    cfc_pkg::GEAR_ONE, 8'hFF));
            send_frame(sealed_frame(16'h5432, 16'h0001, 16'hFC18, cfc_pkg::GEAR_TWO, 8'h00));
            frame = sealed_frame(cfc_pkg::SYNC_WORD_RST, 16'h03E8, 16'h03E9,
                                 cfc_pkg::GEAR_THREE, 8'h5A);
            frame.check_word ^= 16'h8001;
            send_frame(frame);
         end
         // output held off while input keeps coming, so the block backs up
         if (phase == 4) hold_remaining = HOLD_CYCLES;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) send_random_frame();
         drain();
      end

      if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cfc_pkg.sv
rtl/cfc_collector.sv
rtl/cfc_check.sv
rtl/command_frame_checker.sv
tb/testbench.sv
